/* src/mf3_pkg.sv */
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and the compare-exchange helper for the 3x3 median
// filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int PIX_BITS  = 8;
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_BITS = $clog2(MAX_WIDTH);
    localparam int COL_BITS  = 11;
    localparam int ROW_BITS  = 12;
    localparam int CFG_BITS  = 12;
    localparam int WIN_TAPS  = 9;

    localparam int S_TDATA_BITS = 8;
    localparam int M_TDATA_BITS = 32;
    localparam int M_PAD_BITS   = M_TDATA_BITS - PIX_BITS - COL_BITS - ROW_BITS;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [CFG_BITS-1:0] MIN_DIM      = 12'd3;
    localparam logic [CFG_BITS-1:0] MAX_DIM      = CFG_BITS'(MAX_WIDTH);

    // register indexes of the configuration channel
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } mf3_reg_t;

    typedef logic [PIX_BITS-1:0] pix_t;
    typedef pix_t [WIN_TAPS-1:0] win_t;

    typedef struct packed {
        logic                frame_done;
        logic [ROW_BITS-1:0] y;
        logic [COL_BITS-1:0] x;
    } tag_t;

    // order two taps so that the first tap named (a) holds the smaller value
    function automatic win_t ce(win_t w, logic [3:0] a, logic [3:0] b);
        win_t r;
        r = w;
        if (w[a] > w[b])
        begin
            r[a] = w[b];
            r[b] = w[a];
        end
        return r;
    endfunction

endpackage

/* src/median_filter_3x3_unit.sv */
// ----------------------------------------------------------------------------
// median_filter_3x3_unit
// 3x3 median filter over a raster-order 8-bit grayscale pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the s_axis channel, one request per pixel, with tuser set
// on the first pixel of a frame (it restarts the column and row counters;
// after the last pixel of a frame they wrap to the origin on their own).
// Each pixel at column x >= 2 and row y >= 2 completes the window centred on
// (x-1, y-1) and yields one result on m_axis: median, centre coordinates and
// tlast on the last interior result of the frame. Border positions give none.
// Throughput is one pixel per clock unless m_axis stalls: the two line stores
// are read at the accepted column and written back through a separate port as
// the pixel moves on; read data is forwarded on a same-column frame restart.
// A result reaches m_axis through the line store read at the accepting edge,
// then three sorting stages, the first also shifting the window and the third
// being the output register.
// The cfg channel writes image_width (index 0) and image_height (index 1),
// is always ready and should be used only while the pipeline is empty.
// Reset empties the pipeline, zeroes the counters and window and loads
// 640 x 480; the line stores are not cleared. A stalled m_axis holds its
// result; pixels keep flowing until the pipeline stages behind it fill.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mf3_pkg::S_TDATA_BITS-1:0]   s_axis_tdata,  // pixel
    input  logic                               s_axis_tuser,  // frame_start
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mf3_pkg::M_TDATA_BITS-1:0]   m_axis_tdata,  // median, out_x, out_y, pad
    output logic                               m_axis_tlast,  // frame_done
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  mf3_pkg::mf3_reg_t                  cfg_index,
    input  logic [mf3_pkg::CFG_BITS-1:0]       cfg_data
);
    import mf3_pkg::*;

    logic [CFG_BITS-1:0]  width_reg;
    logic [CFG_BITS-1:0]  height_reg;
    logic [COL_BITS-1:0]  col_reg;
    logic [ROW_BITS-1:0]  row_reg;

    pix_t                 upper_mem  [MAX_WIDTH];
    pix_t                 middle_mem [MAX_WIDTH];
    pix_t                 rd_upper_reg;
    pix_t                 rd_middle_reg;

    logic                 v1_reg;
    logic                 emit1_reg;
    pix_t                 pix1_reg;
    logic [ADDR_BITS-1:0] addr1_reg;
    tag_t                 tag1_reg;
    logic                 fwd_reg;
    pix_t                 fwd_upper_reg;
    pix_t                 fwd_middle_reg;
    win_t                 window_reg;
    win_t                 window_next;

    logic                 accept;
    logic                 s1_leave;
    logic [COL_BITS-1:0]  x_in;
    logic [ROW_BITS-1:0]  y_in;
    logic [CFG_BITS-1:0]  w_eff;
    logic [CFG_BITS-1:0]  h_eff;
    logic [COL_BITS:0]    col_plus;
    logic [ROW_BITS:0]    row_plus;
    logic                 row_end;
    logic                 frame_end;
    logic                 emit;
    tag_t                 tag_in;
    pix_t                 top1;
    pix_t                 mid1;
    logic                 med_ready;
    pix_t                 med_out;
    tag_t                 tag_out;

    assign cfg_ready = 1'b1;

    // clamp configured geometry
    always_comb
    begin
        if (width_reg < MIN_DIM)
            w_eff = MIN_DIM;
        else if (width_reg > MAX_DIM)
            w_eff = MAX_DIM;
        else
            w_eff = width_reg;
        h_eff = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    end

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign x_in      = s_axis_tuser ? '0 : col_reg;
    assign y_in      = s_axis_tuser ? '0 : row_reg;
    assign col_plus  = {1'b0, x_in} + 1'b1;
    assign row_plus  = {1'b0, y_in} + 1'b1;
    assign row_end   = col_plus >= w_eff;
    assign frame_end = row_end && (row_plus >= {1'b0, h_eff});
    assign emit      = (x_in >= COL_BITS'(2)) && (y_in >= ROW_BITS'(2));

    always_comb
    begin
        tag_in.x          = x_in - 1'b1;
        tag_in.y          = y_in - 1'b1;
        tag_in.frame_done = frame_end;
    end

    // line store data, forwarded on a same-column back-to-back access
    assign top1 = fwd_reg ? fwd_upper_reg  : rd_upper_reg;
    assign mid1 = fwd_reg ? fwd_middle_reg : rd_middle_reg;

    assign s1_leave      = v1_reg && (!emit1_reg || med_ready);
    assign s_axis_tready = !v1_reg || s1_leave;

    always_comb
    begin
        window_next    = window_reg;
        window_next[0] = window_reg[3];
        window_next[1] = window_reg[4];
        window_next[2] = window_reg[5];
        window_next[3] = window_reg[6];
        window_next[4] = window_reg[7];
        window_next[5] = window_reg[8];
        window_next[6] = top1;
        window_next[7] = mid1;
        window_next[8] = pix1_reg;
    end

    // configuration, counters and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            v1_reg     <= 1'b0;
            fwd_reg    <= 1'b0;
            window_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tready)
                v1_reg <= s_axis_tvalid;
            if (accept)
            begin
                fwd_reg <= v1_reg && (ADDR_BITS'(x_in) == addr1_reg);
                if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= frame_end ? '0 : row_plus[ROW_BITS-1:0];
                end
                else
                begin
                    col_reg <= col_plus[COL_BITS-1:0];
                    row_reg <= y_in;
                end
            end
            if (s1_leave)
                window_reg <= window_next;
        end
    end

    // first stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix1_reg       <= s_axis_tdata[PIX_BITS-1:0];
            addr1_reg      <= ADDR_BITS'(x_in);
            tag1_reg       <= tag_in;
            emit1_reg      <= emit;
            fwd_upper_reg  <= mid1;
            fwd_middle_reg <= pix1_reg;
        end
    end

    // line stores: read on request, write back when the pixel moves on
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_upper_reg  <= upper_mem[ADDR_BITS'(x_in)];
            rd_middle_reg <= middle_mem[ADDR_BITS'(x_in)];
        end
        if (s1_leave)
        begin
            upper_mem[addr1_reg]  <= mid1;
            middle_mem[addr1_reg] <= pix1_reg;
        end
    end

    mf3_median9 u_median9 (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (v1_reg && emit1_reg),
        .in_ready   (med_ready),
        .in_win     (window_next),
        .in_tag     (tag1_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_median (med_out),
        .out_tag    (tag_out)
    );

    assign m_axis_tdata = {{M_PAD_BITS{1'b0}}, tag_out.y, tag_out.x, med_out};
    assign m_axis_tlast = tag_out.frame_done;

endmodule

/* src/mf3_median9.sv */
// ----------------------------------------------------------------------------
// mf3_median9
// Three-stage pipelined median-of-nine sorting network with per-stage flow
// control; a tag travels alongside each request.
// ----------------------------------------------------------------------------
module mf3_median9 (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mf3_pkg::win_t  in_win,
    input  mf3_pkg::tag_t  in_tag,
    output logic           out_valid,
    input  logic           out_ready,
    output mf3_pkg::pix_t  out_median,
    output mf3_pkg::tag_t  out_tag
);
    import mf3_pkg::*;

    logic va_reg;
    logic vb_reg;
    logic vc_reg;
    logic en_a;
    logic en_b;
    logic en_c;
    win_t win_a_reg;
    win_t win_b_reg;
    pix_t med_c_reg;
    tag_t tag_a_reg;
    tag_t tag_b_reg;
    tag_t tag_c_reg;
    win_t sa;
    win_t sb;
    win_t sc;

    assign en_c     = !vc_reg || out_ready;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;

    // sort each row of three
    always_comb
    begin
        sa = in_win;
        sa = ce(sa, 4'd1, 4'd2);
        sa = ce(sa, 4'd4, 4'd5);
        sa = ce(sa, 4'd7, 4'd8);
        sa = ce(sa, 4'd0, 4'd1);
        sa = ce(sa, 4'd3, 4'd4);
        sa = ce(sa, 4'd6, 4'd7);
        sa = ce(sa, 4'd1, 4'd2);
        sa = ce(sa, 4'd4, 4'd5);
        sa = ce(sa, 4'd7, 4'd8);
    end

    // column pass
    always_comb
    begin
        sb = win_a_reg;
        sb = ce(sb, 4'd0, 4'd3);
        sb = ce(sb, 4'd5, 4'd8);
        sb = ce(sb, 4'd4, 4'd7);
        sb = ce(sb, 4'd3, 4'd6);
        sb = ce(sb, 4'd1, 4'd4);
        sb = ce(sb, 4'd2, 4'd5);
        sb = ce(sb, 4'd4, 4'd7);
    end

    // diagonal pass, median lands in tap four
    always_comb
    begin
        sc = win_b_reg;
        sc = ce(sc, 4'd4, 4'd2);
        sc = ce(sc, 4'd6, 4'd4);
        sc = ce(sc, 4'd4, 4'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
                va_reg <= in_valid;
            if (en_b)
                vb_reg <= va_reg;
            if (en_c)
                vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            win_a_reg <= sa;
            tag_a_reg <= in_tag;
        end
        if (en_b)
        begin
            win_b_reg <= sb;
            tag_b_reg <= tag_a_reg;
        end
        if (en_c)
        begin
            med_c_reg <= sc[4];
            tag_c_reg <= tag_b_reg;
        end
    end

    assign out_valid  = vc_reg;
    assign out_median = med_c_reg;
    assign out_tag    = tag_c_reg;

endmodule

/* src/mf3_checker.sv */
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks for the 3x3 median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mf3_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [mf3_pkg::M_TDATA_BITS-1:0]   m_axis_tdata,  // median, out_x, out_y, pad
    input  logic                               m_axis_tlast,  // frame_done
    input  logic                               cfg_ready
);
    import mf3_pkg::*;

    localparam int X_LO = PIX_BITS;
    localparam int X_HI = PIX_BITS + COL_BITS - 1;
    localparam int Y_LO = PIX_BITS + COL_BITS;
    localparam int Y_HI = PIX_BITS + COL_BITS + ROW_BITS - 1;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // reported columns are never column 0 nor column MAX_WIDTH-1
    a_x_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[X_HI:X_LO] != '0) &&
            (m_axis_tdata[X_HI:X_LO] != COL_BITS'(MAX_WIDTH - 1)))
        else $error("column outside interior");

    // reported rows are never row 0
    a_y_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[Y_HI:Y_LO] != '0)
        else $error("row outside interior");

    // padding bits stay clear and the config channel never blocks
    a_pad_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready && (!m_axis_tvalid || m_axis_tdata[M_TDATA_BITS-1:Y_HI+1] == '0))
        else $error("pad bits set or config channel blocked");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (.*);
